### src/gdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdt_pkg - shared types and constants of the distance thinning core
// Field widths, register reset values, register indexes and the status
// record passed from the distance unit to the sequencer.
// ----------------------------------------------------------------------------
package gdt_pkg;

	// default sizing of the kept set and of the coordinates
	localparam int MAX_SET_DEF    = 32;
	localparam int COORD_BITS_DEF = 24;

	// fixed field widths
	localparam int DIST_W = 52;
	localparam int KEEP_W = 6;
	localparam int TAG_W  = 16;

	// axis magnitudes at or above 2^FAR_BITS never reject
	localparam int FAR_BITS = 26;
	// magnitude width at the widest allowed coordinate
	localparam int EXT_W    = 33;
	localparam int SQ_W     = 2 * FAR_BITS;
	localparam int SUM_W    = SQ_W + 2;

	// register reset values: 0.2 m spacing squared, twenty positions
	localparam logic [DIST_W-1:0] MIN_DIST_SQ_RST = DIST_W'(41943);
	localparam logic [KEEP_W-1:0] MAX_KEPT_RST    = KEEP_W'(20);

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_DIST_SQ = 2'd0,
		CFG_MAX_KEPT    = 2'd1
	} cfg_idx_t;

	// one compare result from the distance unit
	typedef struct packed {
		logic valid;
		logic hit;
	} dist_res_t;

endpackage

`default_nettype wire

### src/greedy_distance_thinning_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_distance_thinning_core - greedy thinning of 3D positions by spacing
// Present candidates best first. Each one is compared with every kept
// position of the batch; it is kept when no squared distance is below
// min_dist_sq and the set is not yet full. batch_start (tuser) empties the
// set before its own beat is judged. One result beat per input beat.
// An item that has to be scanned runs through ST_SCAN, ST_WAIT and ST_FINISH,
// and all count positions already kept are compared with it: the kept set is
// read one entry per cycle from a single RAM port into a three stage distance
// unit. An item that meets an empty or a full set skips the scan and goes
// straight to ST_FINISH. At the default size of 32 at most 31 entries are
// scanned. The input is not ready while an item is being judged, and a result
// beat still waiting on the output holds the core in its last step.
// ----------------------------------------------------------------------------
module greedy_distance_thinning_core #(
	parameter int MAX_SET    = gdt_pkg::MAX_SET_DEF,
	parameter int COORD_BITS = gdt_pkg::COORD_BITS_DEF,
	localparam int IN_BITS   = 3 * COORD_BITS + gdt_pkg::TAG_W,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input stream
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	input  wire logic [IN_W-1:0]            s_tdata,  // pos_x, pos_y, pos_z, item_id
	input  wire logic                       s_tuser,  // batch_start
	// result stream
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [23:0]                m_tdata,  // kept, tag_out, kept_count, set_full
	// configuration writes
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [gdt_pkg::DIST_W-1:0] cfg_data
);

	localparam int POS_W  = 3 * COORD_BITS;
	localparam int CNT_W  = $clog2(MAX_SET + 1);
	localparam int IDX_W  = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
	localparam int KW     = gdt_pkg::KEEP_W;
	localparam int LIM_W  = (CNT_W > KW) ? CNT_W : KW;
	localparam int TW     = gdt_pkg::TAG_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	logic [gdt_pkg::DIST_W-1:0] min_dist_sq_q;
	logic [KW-1:0]             max_kept_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic [CNT_W-1:0]          ret_q;
	logic                      hit_q;
	logic                      keep_q;
	logic                      rd_vld_q;
	logic [POS_W-1:0]          cand_q;
	logic [TW-1:0]             tag_q;
	logic                      m_tvalid_q;
	logic [23:0]               m_tdata_q;

	logic [LIM_W-1:0]          lim;
	logic [LIM_W-1:0]          max_kept_ext;
	logic [CNT_W-1:0]          cnt_start;
	logic [CNT_W-1:0]          idx_next;
	logic [CNT_W-1:0]          count_new;
	logic                      out_free;
	logic                      rd_en;
	logic                      wr_en;
	logic [POS_W-1:0]          rd_data;
	gdt_pkg::dist_res_t        dres;

	// effective limit, clamped to the set size
	assign max_kept_ext = LIM_W'(max_kept_q);
	assign lim = (max_kept_ext > LIM_W'(MAX_SET)) ? LIM_W'(MAX_SET) : max_kept_ext;

	assign cnt_start = s_tuser ? '0 : count_q;
	assign idx_next  = idx_q + CNT_W'(1);
	assign count_new = keep_q ? count_q + CNT_W'(1) : count_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign rd_en = (state_q == ST_SCAN);
	assign wr_en = (state_q == ST_FINISH) && out_free && keep_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_sq_q <= gdt_pkg::MIN_DIST_SQ_RST;
			max_kept_q    <= gdt_pkg::MAX_KEPT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gdt_pkg::CFG_MIN_DIST_SQ: min_dist_sq_q <= cfg_data;
				gdt_pkg::CFG_MAX_KEPT:    max_kept_q    <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: scan kept set, collect compare results, emit result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			ret_q      <= '0;
			hit_q      <= 1'b0;
			keep_q     <= 1'b0;
			rd_vld_q   <= 1'b0;
			cand_q     <= '0;
			tag_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			rd_vld_q <= rd_en;
			// the last step reloads the result register itself
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			if (dres.valid) begin
				ret_q <= ret_q + CNT_W'(1);
				if (dres.hit) begin
					hit_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cand_q  <= s_tdata[POS_W-1:0];
						tag_q   <= s_tdata[POS_W +: TW];
						count_q <= cnt_start;
						idx_q   <= '0;
						ret_q   <= '0;
						hit_q   <= 1'b0;
						if (LIM_W'(cnt_start) >= lim) begin
							keep_q  <= 1'b0;
							state_q <= ST_FINISH;
						end else if (cnt_start == '0) begin
							keep_q  <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_next;
					if (idx_next == count_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (ret_q == count_q) begin
						keep_q  <= !hit_q;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(LIM_W'(count_new) >= lim), KW'(count_new),
							tag_q, keep_q};
						count_q    <= count_new;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// kept position store
	gdt_ram #(
		.WIDTH (POS_W),
		.DEPTH (MAX_SET)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (cand_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// shared distance compare unit
	gdt_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rd_vld_q),
		.entry       (rd_data),
		.cand        (cand_q),
		.min_dist_sq (min_dist_sq_q),
		.res         (dres)
	);

`ifndef ASSERT_OFF
	// the set never holds more than its size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SET))
		else $error("kept count beyond set size");

	// a position is only stored while the set has room
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (LIM_W'(count_q) < lim))
		else $error("store into full set");

	// compare results only arrive while an item is being scanned
	a_result_window: assert property (@(posedge clk) disable iff (!arst_n)
		dres.valid |-> (state_q == ST_SCAN || state_q == ST_WAIT))
		else $error("stray compare result");

	// never more compare results than entries scanned
	a_ret_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ret_q <= count_q)
		else $error("compare result overrun");

	// an accepted beat blocks the input on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready while busy");
`endif

endmodule

`default_nettype wire

### src/gdt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdt_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/gdt_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdt_dist - pipelined squared distance compare
// Takes one kept entry per cycle against the candidate and reports whether
// the squared distance lies strictly below the threshold.
// ----------------------------------------------------------------------------
module gdt_dist #(
	parameter int COORD_BITS = gdt_pkg::COORD_BITS_DEF,
	localparam int POS_W = 3 * COORD_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [POS_W-1:0]            entry,
	input  wire logic [POS_W-1:0]            cand,
	input  wire logic [gdt_pkg::DIST_W-1:0]  min_dist_sq,
	output      gdt_pkg::dist_res_t          res
);

	localparam int MAG_W = COORD_BITS + 1;
	localparam int EW    = gdt_pkg::EXT_W;
	localparam int FB    = gdt_pkg::FAR_BITS;

	logic [FB-1:0]               op_s1 [3];
	logic                        far_s1;
	logic                        vld_s1;
	logic [gdt_pkg::SQ_W-1:0]    sq_s2 [3];
	logic                        far_s2;
	logic                        vld_s2;
	logic                        hit_s3;
	logic                        vld_s3;

	logic [FB-1:0]               op_c  [3];
	logic [2:0]                  far_c;
	logic [gdt_pkg::SUM_W-1:0]   sum_c;

	// axis differences, magnitudes and far detection
	always_comb begin
		logic signed [MAG_W-1:0] d;
		logic [MAG_W-1:0]        m;
		logic [EW-1:0]           ext;
		for (int a = 0; a < 3; a++) begin
			d = $signed({entry[a*COORD_BITS+COORD_BITS-1],
				entry[a*COORD_BITS +: COORD_BITS]})
				- $signed({cand[a*COORD_BITS+COORD_BITS-1],
				cand[a*COORD_BITS +: COORD_BITS]});
			m = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
			ext = EW'(m);
			far_c[a] = |ext[EW-1:FB];
			op_c[a] = ext[FB-1:0];
		end
	end

	// sum of squares
	assign sum_c = gdt_pkg::SUM_W'(sq_s2[0]) + gdt_pkg::SUM_W'(sq_s2[1])
		+ gdt_pkg::SUM_W'(sq_s2[2]);

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// data pipeline: magnitudes, squares, compare
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			op_s1[a] <= op_c[a];
			sq_s2[a] <= op_s1[a] * op_s1[a];
		end
		far_s1 <= |far_c;
		far_s2 <= far_s1;
		hit_s3 <= !far_s2 && (sum_c < gdt_pkg::SUM_W'(min_dist_sq));
	end

	assign res.valid = vld_s3;
	assign res.hit   = hit_s3;

endmodule

`default_nettype wire

### tb/sv/gdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_checker - result checker for the distance thinning core
// Watches the configuration, candidate and result channels. Every accepted
// candidate beat is judged against a private copy of the kept set and the
// register values. The verdict joins a queue. Each accepted result beat is
// compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module gdt_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	input  wire logic                       s_tready,
	input  wire logic [87:0]                s_tdata,  // pos_x, pos_y, pos_z, item_id
	input  wire logic                       s_tuser,  // batch_start
	input  wire logic                       m_tvalid,
	input  wire logic                       m_tready,
	input  wire logic [23:0]                m_tdata,  // kept, tag_out, kept_count, set_full
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [gdt_pkg::DIST_W-1:0] cfg_data,
	output int                              fails,
	output int                              pending
);
	import gdt_pkg::*;

	typedef longint unsigned u64_t;

	// one result beat, members listed from the top bit down
	typedef struct packed {
		logic              full;
		logic [KEEP_W-1:0] count;
		logic [TAG_W-1:0]  tag;
		logic              kept;
	} verdict_t;

	verdict_t verdicts_due[$];

	// private copy of the kept set and of the registers
	logic signed [COORD_BITS_DEF-1:0] set_x [MAX_SET_DEF];
	logic signed [COORD_BITS_DEF-1:0] set_y [MAX_SET_DEF];
	logic signed [COORD_BITS_DEF-1:0] set_z [MAX_SET_DEF];
	int unsigned                      n_kept;
	logic [DIST_W-1:0]                spacing_sq;
	logic [KEEP_W-1:0]                keep_limit;

	// squared distance to kept entry idx strictly below the spacing
	function automatic bit closer_than(input int idx,
			input logic signed [COORD_BITS_DEF-1:0] px, py, pz);
		longint d [3];
		u64_t   m;
		u64_t   acc;
		acc = 0;
		d[0] = longint'(px) - longint'(set_x[idx]);
		d[1] = longint'(py) - longint'(set_y[idx]);
		d[2] = longint'(pz) - longint'(set_z[idx]);
		for (int a = 0; a < 3; a++) begin
			m = (d[a] < 0) ? -d[a] : d[a];
			// any axis this far apart can never reject
			if (m >= (u64_t'(1) << FAR_BITS))
				return 1'b0;
			acc += m * m;
		end
		return acc < u64_t'(spacing_sq);
	endfunction

	// judge one candidate and update the kept set
	function automatic verdict_t judge_candidate(input logic [87:0] beat, input logic restart);
		logic signed [COORD_BITS_DEF-1:0] px, py, pz;
		int unsigned lim;
		bit          ok;
		verdict_t    v;
		px  = beat[23:0];
		py  = beat[47:24];
		pz  = beat[71:48];
		lim = (keep_limit > MAX_SET_DEF) ? MAX_SET_DEF : keep_limit;
		ok  = 1'b0;
		if (restart)
			n_kept = 0;
		if (n_kept < lim) begin
			ok = 1'b1;
			for (int i = 0; i < n_kept; i++)
				if (closer_than(i, px, py, pz))
					ok = 1'b0;
			if (ok) begin
				set_x[n_kept] = px;
				set_y[n_kept] = py;
				set_z[n_kept] = pz;
				n_kept++;
			end
		end
		v.kept  = ok;
		v.tag   = beat[87:72];
		v.count = KEEP_W'(n_kept);
		v.full  = (n_kept >= lim);
		return v;
	endfunction

	// results are checked before a candidate of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			verdicts_due.delete();
			n_kept     = 0;
			spacing_sq = MIN_DIST_SQ_RST;
			keep_limit = MAX_KEPT_RST;
			fails      = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (verdicts_due.size() == 0) begin
					$error("result beat with nothing outstanding, tag_out %0d", got.tag);
					fails++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.kept !== want.kept) begin
						$error("kept: expected %0d, actual %0d", want.kept, got.kept);
						fails++;
					end
					if (got.tag !== want.tag) begin
						$error("tag_out: expected %0d, actual %0d", want.tag, got.tag);
						fails++;
					end
					if (got.count !== want.count) begin
						$error("kept_count: expected %0d, actual %0d", want.count, got.count);
						fails++;
					end
					if (got.full !== want.full) begin
						$error("set_full: expected %0d, actual %0d", want.full, got.full);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MIN_DIST_SQ)
					spacing_sq = cfg_data;
				else if (cfg_index == CFG_MAX_KEPT)
					keep_limit = cfg_data[KEEP_W-1:0];
			end
			// append the verdict at the tail of the queue
			if (s_tvalid && s_tready)
				verdicts_due.insert(verdicts_due.size(),
					judge_candidate(s_tdata, s_tuser));
			pending = verdicts_due.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of greedy_distance_thinning_core
// Drives candidate beats in bursts: a directed opening over the field
// extremes, exact spacing, limit changes and the zero limit, then random
// batches clustered around the configured spacing under several register
// settings. The result side stalls on its own pattern, with long hold-offs.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import gdt_pkg::*;

	localparam int IN_W        = 3 * COORD_BITS_DEF + TAG_W;
	localparam int ITEMS       = 1150;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_BEAT
	} sink_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;  // pos_x, pos_y, pos_z, item_id
	logic              s_tuser   = 1'b0;  // batch_start
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [23:0]       m_tdata;  // kept, tag_out, kept_count, set_full
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_idx_t          cfg_index = CFG_MIN_DIST_SQ;
	logic [DIST_W-1:0] cfg_data  = '0;

	int fails;
	int pending;
	int results_seen = 0;
	int idle_cycles  = 0;
	int burst_left   = 0;
	int gap_max      = 0;

	always #1 clk = ~clk;

	greedy_distance_thinning_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gdt_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	// one candidate beat, opening a new burst after a random gap
	task automatic push_item(input logic [23:0] px, py, pz, input logic [15:0] id,
			input logic restart);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, gap_max)) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {id, pz, py, px};
		s_tuser  <= restart;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DIST_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain every outstanding result, then let the core go idle
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// random batches clustered around the spacing under one register setting
	task automatic run_phase(input int ph, input int n_items);
		longint unsigned thr;
		int              r, span, len, done, roll, off;
		logic [5:0]      lim;
		logic [23:0]     cx, cy, cz, px, py, pz;
		logic            bs;
		r = $urandom_range(1, 3000);
		case ($urandom_range(0, 3))
			0: thr = r * r;
			1: thr = r * r + 1;
			2: thr = r * r - 1;
			default: thr = {$urandom, $urandom};
		endcase
		case (ph)
			0: lim = 6'd32;
			1: lim = 6'd1;
			2: lim = 6'd63;
			3: lim = 6'd0;
			default: lim = 6'($urandom_range(2, 36));
		endcase
		gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
		settle();
		write_reg(CFG_MIN_DIST_SQ, DIST_W'(thr));
		write_reg(CFG_MAX_KEPT, DIST_W'(lim));
		done = 0;
		px   = '0;
		py   = '0;
		pz   = '0;
		while (done < n_items) begin
			len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70) : $urandom_range(4, 30);
			span = r * $urandom_range(1, 6);
			cx   = 24'($urandom);
			cy   = 24'($urandom);
			cz   = 24'($urandom);
			// the odd batch carries on from the previous set
			bs   = ($urandom_range(0, 9) != 0);
			for (int i = 0; i < len && done < n_items; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					// noise anywhere in the coordinate range
					px = 24'($urandom);
					py = 24'($urandom);
					pz = 24'($urandom);
					bs = 1'($urandom_range(0, 1));
				end else if (roll < 18) begin
					// exactly one spacing away from the last candidate
					off = $urandom_range(0, 1) ? r : -r;
					case ($urandom_range(0, 2))
						0: px += 24'(off);
						1: py += 24'(off);
						default: pz += 24'(off);
					endcase
				end else if (roll >= 22) begin
					px = cx + 24'($urandom_range(0, 2 * span)) - 24'(span);
					py = cy + 24'($urandom_range(0, 2 * span)) - 24'(span);
					pz = cz + 24'($urandom_range(0, 2 * span)) - 24'(span);
				end
				push_item(px, py, pz, 16'($urandom), bs);
				bs = 1'b0;
				done++;
			end
		end
	endtask

	// count delivered results for the hold-off trigger
	always @(posedge clk)
		if (m_tvalid && m_tready)
			results_seen <= results_seen + 1;

	// result side: stretches of differing stall patterns, two long hold-offs
	initial begin : sink
		sink_mode_t mode;
		int         holds_done;
		int         phase_ctr;
		holds_done = 0;
		phase_ctr  = 0;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 200)) begin
				@(negedge clk);
				phase_ctr++;
				if (holds_done < 2 && results_seen >= (holds_done + 1) * 350) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					holds_done++;
				end
				case (mode)
					SINK_OPEN:   m_tready <= 1'b1;
					SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:     m_tready <= (phase_ctr % 8) < 5;
				endcase
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int ph;
		int total;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults: 0.2 m spacing, twenty kept
		gap_max = 3;
		push_item(24'd0, 24'd0, 24'd0, 16'h0000, 1'b1);
		push_item(24'd0, 24'd0, 24'd204, 16'd1, 1'b0);
		push_item(24'd0, 24'd0, 24'd205, 16'd2, 1'b0);
		push_item(24'h800000, 24'h800000, 24'h800000, 16'd3, 1'b0);
		push_item(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff, 1'b0);
		push_item(24'h7fffff, 24'h7fffff, 24'h7fff40, 16'haaaa, 1'b0);
		push_item(24'h800000, 24'd0, 24'h7fffff, 16'h5555, 1'b0);

		// spacing of exactly 200, limit of three
		settle();
		write_reg(CFG_MIN_DIST_SQ, DIST_W'(40000));
		write_reg(CFG_MAX_KEPT, DIST_W'(3));
		push_item(24'd100, 24'd100, 24'd100, 16'd7, 1'b1);
		push_item(24'd300, 24'd100, 24'd100, 16'd8, 1'b0);
		push_item(24'd100, 24'd100, -24'sd99, 16'd9, 1'b0);
		push_item(-24'sd100, 24'd100, 24'd100, 16'd10, 1'b0);
		push_item(24'd5000, 24'd5000, 24'd5000, 16'd11, 1'b0);

		// limit lowered below the count already kept
		settle();
		write_reg(CFG_MAX_KEPT, DIST_W'(2));
		push_item(-24'sd5000, -24'sd5000, -24'sd5000, 16'd12, 1'b0);

		// zero limit
		settle();
		write_reg(CFG_MAX_KEPT, DIST_W'(0));
		push_item(24'd0, 24'd0, 24'd0, 16'd13, 1'b1);

		// widest spacing rejects everything once one is kept
		settle();
		write_reg(CFG_MIN_DIST_SQ, {DIST_W{1'b1}});
		write_reg(CFG_MAX_KEPT, DIST_W'(63));
		push_item(24'h800000, 24'h800000, 24'h800000, 16'd14, 1'b1);
		push_item(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'd15, 1'b0);

		// zero spacing lets a repeated position through
		settle();
		write_reg(CFG_MIN_DIST_SQ, '0);
		push_item(24'd1, 24'd2, 24'd3, 16'd16, 1'b1);
		push_item(24'd1, 24'd2, 24'd3, 16'd17, 1'b0);

		ph    = 0;
		total = 0;
		while (total < ITEMS) begin
			run_phase(ph, (ph == 3) ? 40 : 115);
			total += (ph == 3) ? 40 : 115;
			ph++;
		end

		settle();
		repeat (40) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### filelist.f
src/gdt_pkg.sv
src/gdt_ram.sv
src/gdt_dist.sv
src/greedy_distance_thinning_core.sv
tb/sv/gdt_checker.sv
tb/sv/tb_top.sv
